// ===== design/bifid_pkg.sv =====
// Shared types, constants and helpers for the bifid cipher block.
// No dependencies; imported by bifid_ctrl, bifid_dp and bifid_cipher_period5.
package bifid_pkg;

	localparam int PERIOD   = 5;
	localparam int CNT_W    = $clog2(PERIOD + 1);
	localparam int IDX_W    = (PERIOD > 1) ? $clog2(PERIOD) : 1;
	localparam int SEQ_W    = $clog2(2 * PERIOD) + 1;

	localparam int LETTERS  = 26;
	localparam int CELLS    = 25;
	localparam int SIDE     = 5;

	localparam logic [4:0] LETTER_I = 5'd8;
	localparam logic [4:0] LETTER_J = 5'd9;

	localparam int TDATA_W  = 8;

	localparam logic [1:0] REQ_CLEAR  = 2'd0;
	localparam logic [1:0] REQ_KEY    = 2'd1;
	localparam logic [1:0] REQ_FINISH = 2'd2;
	localparam logic [1:0] REQ_MSG    = 2'd3;

	typedef struct packed {
		logic take;     // input transaction accepted
		logic walk;     // one step of the alphabet fill
		logic fetch_a;  // latch first coordinate of the output pair
		logic load;     // fetch second coordinate, load output register
	} cmd_t;

	typedef struct packed {
		logic start_walk;
		logic start_emit;
		logic walk_last;
		logic k_last;
		logic out_free;
	} sts_t;

	// cell number n (0..24) to row*8+col
	function automatic logic [5:0] pos_of(input logic [4:0] n);
		logic [2:0] row;
		logic [4:0] base;
		logic [4:0] col;
		if (n >= 5'd20)      row = 3'd4;
		else if (n >= 5'd15) row = 3'd3;
		else if (n >= 5'd10) row = 3'd2;
		else if (n >= 5'd5)  row = 3'd1;
		else                 row = 3'd0;
		base = ({2'b00, row} << 2) + {2'b00, row};
		col  = n - base;
		return {row, col[2:0]};
	endfunction

	function automatic logic [2:0] clamp4(input logic [2:0] v);
		return (v > 3'd4) ? 3'd4 : v;
	endfunction

endpackage

// ===== design/bifid_ctrl.sv =====
// Sequencing controller for the bifid cipher: input handshake, alphabet
// walk and output emission. Depends on bifid_pkg.
module bifid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  bifid_pkg::sts_t  sts,
	output bifid_pkg::cmd_t  cmd
);
	import bifid_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FETCH = 2'd2;
	localparam logic [1:0] ST_OUT   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.start_walk)
						state_d = ST_WALK;
					else if (sts.start_emit)
						state_d = ST_FETCH;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_last)
					state_d = ST_IDLE;
			end
			ST_FETCH: begin
				cmd.fetch_a = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				// wait until the output register can take the letter
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = sts.k_last ? ST_IDLE : ST_FETCH;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/bifid_dp.sv =====
// Datapath of the bifid cipher: key square, letter positions, block
// coordinates, sequence reader and output register. Depends on bifid_pkg.
module bifid_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  bifid_pkg::cmd_t  cmd,
	output bifid_pkg::sts_t  sts,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic [1:0]       req_type,
	input  logic [4:0]       letter,
	input  logic             msg_last,
	input  logic             m_ready,
	output logic             m_valid,
	output logic [4:0]       out_letter,
	output logic             run_last,
	output logic             msg_end
);
	import bifid_pkg::*;

	// stores without reset
	logic [4:0] key_sq_q    [CELLS];
	logic [5:0] pos_q       [LETTERS];
	logic [2:0] blk_row_q   [PERIOD];
	logic [2:0] blk_col_q   [PERIOD];
	logic [2:0] coord_a_q;
	logic [4:0] out_letter_q;
	logic       run_last_q;
	logic       msg_end_q;
	logic       blk_last_q;

	// control state
	logic [LETTERS-1:0] used_q;
	logic [4:0]         fill_q;
	logic [4:0]         walk_q;
	logic [CNT_W-1:0]   blk_cnt_q;
	logic [CNT_W-1:0]   k_q;
	logic               out_valid_q;
	logic               decrypt_q;

	logic               lt_ok;
	logic [4:0]         lt_map;
	logic               is_msg;
	logic [CNT_W-1:0]   cnt_next;
	logic               place_en;
	logic [4:0]         place_lt;
	logic               k_last;
	logic [SEQ_W-1:0]   j_a;
	logic [SEQ_W-1:0]   j_b;
	logic [SEQ_W-1:0]   j_sel;
	logic [SEQ_W-1:0]   j_off;
	logic [SEQ_W-1:0]   j_half;
	logic [SEQ_W-1:0]   n_ext;
	logic [SEQ_W-1:0]   k_ext;
	logic [2:0]         elem;
	logic [2:0]         row_c;
	logic [2:0]         col_c;
	logic [4:0]         cell_idx;

	assign lt_ok    = (letter < 5'(LETTERS));
	assign lt_map   = (letter == LETTER_J) ? LETTER_I : letter;
	assign is_msg   = (req_type == REQ_MSG);
	assign cnt_next = blk_cnt_q + CNT_W'(lt_ok);

	assign sts.start_walk = (req_type == REQ_FINISH);
	assign sts.start_emit = is_msg && ((lt_ok && (cnt_next == CNT_W'(PERIOD)))
		|| (msg_last && (cnt_next != '0)));
	assign sts.walk_last  = (walk_q == 5'(LETTERS - 1));

	// one placement path shared by key letters and the alphabet walk
	always_comb begin
		place_en = 1'b0;
		place_lt = walk_q;
		if (cmd.take && (req_type == REQ_KEY) && lt_ok) begin
			place_lt = lt_map;
			place_en = !used_q[lt_map] && (fill_q < 5'(CELLS));
		end else if (cmd.walk) begin
			place_en = !used_q[walk_q] && (fill_q < 5'(CELLS));
		end
	end

	assign k_last = ((k_q + CNT_W'(1)) == blk_cnt_q);

	// sequence positions of the two coordinates of output k
	assign n_ext = SEQ_W'(blk_cnt_q);
	assign k_ext = SEQ_W'(k_q);
	assign j_a   = decrypt_q ? k_ext : (k_ext << 1);
	assign j_b   = decrypt_q ? (k_ext + n_ext) : ((k_ext << 1) + SEQ_W'(1));
	assign j_sel = cmd.fetch_a ? j_a : j_b;
	assign j_off = j_sel - n_ext;
	assign j_half = j_sel >> 1;

	always_comb begin
		if (!decrypt_q) begin
			// rows of the block, then its columns
			if (j_sel < n_ext)
				elem = blk_row_q[j_sel[IDX_W-1:0]];
			else
				elem = blk_col_q[j_off[IDX_W-1:0]];
		end else begin
			// interleaved (row, col) pairs
			if (j_sel[0])
				elem = blk_col_q[j_half[IDX_W-1:0]];
			else
				elem = blk_row_q[j_half[IDX_W-1:0]];
		end
	end

	assign row_c    = clamp4(coord_a_q);
	assign col_c    = clamp4(elem);
	assign cell_idx = ({2'b00, row_c} << 2) + {2'b00, row_c} + {2'b00, col_c};

	assign sts.k_last   = k_last;
	assign sts.out_free = !out_valid_q || m_ready;

	always_ff @(posedge clk) begin
		if (place_en) begin
			key_sq_q[fill_q] <= place_lt;
			pos_q[place_lt]  <= pos_of(fill_q);
		end
		if (cmd.take && is_msg) begin
			blk_last_q <= msg_last;
			if (lt_ok) begin
				blk_row_q[blk_cnt_q[IDX_W-1:0]] <= pos_q[lt_map][5:3];
				blk_col_q[blk_cnt_q[IDX_W-1:0]] <= pos_q[lt_map][2:0];
			end
		end
		if (cmd.fetch_a)
			coord_a_q <= elem;
		if (cmd.load) begin
			out_letter_q <= key_sq_q[cell_idx];
			run_last_q   <= k_last;
			msg_end_q    <= blk_last_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			fill_q      <= '0;
			walk_q      <= '0;
			blk_cnt_q   <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			decrypt_q   <= 1'b0;
		end else begin
			if (cfg_we)
				decrypt_q <= cfg_wdata;
			if (cmd.take && (req_type == REQ_CLEAR)) begin
				used_q <= '0;
				fill_q <= '0;
			end else if (place_en) begin
				used_q[place_lt] <= 1'b1;
				if (place_lt == LETTER_I)
					used_q[LETTER_J] <= 1'b1;
				fill_q <= fill_q + 5'd1;
			end
			if (cmd.take && sts.start_walk)
				walk_q <= '0;
			else if (cmd.walk)
				walk_q <= walk_q + 5'd1;
			if (cmd.take && is_msg) begin
				blk_cnt_q <= cnt_next;
				k_q       <= '0;
			end else if (cmd.load) begin
				if (k_last) begin
					blk_cnt_q <= '0;
					k_q       <= '0;
				end else begin
					k_q <= k_q + CNT_W'(1);
				end
			end
			if (cmd.load)
				out_valid_q <= 1'b1;
			else if (m_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_valid    = out_valid_q;
	assign out_letter = out_letter_q;
	assign run_last   = run_last_q;
	assign msg_end    = msg_end_q;

endmodule

// ===== design/bifid_cipher_period5.sv =====
// Bifid cipher, 5x5 keyed square (I and J share a cell), period 5. Key
// items build the square: clear key and key letters are accepted while idle,
// and key finish walks the alphabet. A message letter is accepted while idle;
// the letter that closes a block (fifth letter or tlast) is followed by the
// emission of its output letters: for each, the block is read one
// coordinate per cycle unless the output stalls, and a single key-square
// lookup loads the output register. The input is not ready during the walk
// or emission. Results sit in an output register, so a new input can be
// taken while one waits. Depends on bifid_pkg, bifid_ctrl and bifid_dp.
module bifid_cipher_period5 (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_wdata,    // decrypt_mode
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bifid_pkg::TDATA_W-1:0] s_tdata,      // [4:0] letter
	input  logic [1:0]                    s_tuser,      // [1:0] req_type
	input  logic                          s_tlast,      // msg_last
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [bifid_pkg::TDATA_W-1:0] m_tdata,      // [4:0] out_letter
	output logic [0:0]                    m_tuser,      // [0] msg_end
	output logic                          m_tlast       // run_last
);
	import bifid_pkg::*;

	cmd_t       cmd;
	sts_t       sts;
	logic [4:0] out_letter;
	logic       msg_end;

	bifid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bifid_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req_type   (s_tuser),
		.letter     (s_tdata[4:0]),
		.msg_last   (s_tlast),
		.m_ready    (m_tready),
		.m_valid    (m_tvalid),
		.out_letter (out_letter),
		.run_last   (m_tlast),
		.msg_end    (msg_end)
	);

	assign m_tdata = {{(TDATA_W - 5){1'b0}}, out_letter};
	assign m_tuser = msg_end;

endmodule
